>>> src/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int COUNT_W   = IDX_W + 1;
  localparam int SIZE_W    = 17;
  localparam int BOFF_W    = 28;
  localparam int MAG_W     = BOFF_W - 1;
  localparam int AOFF_W    = 26;
  localparam int REM_W     = SIZE_W;
  localparam int SUM_W     = MAG_W + 1;
  localparam int DIV_STEPS = MAG_W;
  localparam int MUL_STEPS = IDX_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_RESET = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_NO_MEMORY       = 2'd1,
    ST_INVALID_POINTER = 2'd2,
    ST_FREE_LIST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_SLOT_COUNT    = 2'd0,
    REG_DATUM_SIZE    = 2'd1,
    REG_FREE_LIST_LEN = 2'd2
  } reg_index_t;

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } arith_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    arith_op_t        op;
    logic [MAG_W-1:0] operand;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] result;
    logic             rem_zero;
  } arith_rsp_t;

  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
  } ring_req_t;

endpackage

`default_nettype wire

>>> src/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator with a ring free list.
//
// Channel   Direction  Handshake                  Content
// s_axis    in         s_axis_tvalid/tready       tuser: mode, tdata: free_offset
// m_axis    out        m_axis_tvalid/tready       tuser: status, tdata: slot_index, offset
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// An allocate runs one ring read, 10 shift-add steps of the shared adder and the
// two result stages.
// A free runs the 27 restoring division steps on the same adder; a negative offset,
// an allocate on an empty ring, a pool reset and an unused mode go straight to the
// result stages.
// One item is in work at a time; s_axis_tready is high only while idle.
// The result register lets the next item in while a result waits on m_axis_tready.
// Reset leaves the ring full with entry i holding i, with no clearing pass.
`default_nettype none

module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [27:0] free_offset
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [9:0] slot_index, [35:10] alloc_offset
  output logic [1:0]       m_axis_tuser,  // [1:0] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  state_t             state;
  state_t             state_next;

  logic [COUNT_W-1:0] slot_count;
  logic [SIZE_W-1:0]  block_bytes;
  logic [COUNT_W-1:0] free_list_len;

  logic [IDX_W-1:0]   rd_ptr;
  logic [IDX_W-1:0]   wr_ptr;
  logic [COUNT_W-1:0] free_count;
  logic [COUNT_W-1:0] ring_len;

  status_t            res_status;
  logic [IDX_W-1:0]   res_idx;
  logic [AOFF_W-1:0]  res_off;
  status_t            res_status_next;
  logic [IDX_W-1:0]   res_idx_next;
  logic [AOFF_W-1:0]  res_off_next;
  logic               res_load;

  logic               out_valid;
  status_t            out_status;
  logic [IDX_W-1:0]   out_idx;
  logic [AOFF_W-1:0]  out_off;
  logic               out_load;

  logic               pop;
  logic               push;
  logic               pool_reset;
  logic               accept;
  mode_t              mode;
  logic [BOFF_W-1:0]  free_offset;
  logic [SIZE_W-1:0]  dsize;
  logic [COUNT_W-1:0] bound;
  logic [COUNT_W-1:0] len_sat;

  arith_req_t         arith_req;
  arith_rsp_t         arith_rsp;
  ring_req_t          ring_req;
  logic [IDX_W-1:0]   ring_data;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] p,
                                               input logic [COUNT_W-1:0] len);
    logic [COUNT_W-1:0] n;
    n = COUNT_W'(p) + 1'b1;
    return (n >= len) ? '0 : n[IDX_W-1:0];
  endfunction

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign mode        = mode_t'(s_axis_tuser);
  assign free_offset = s_axis_tdata[BOFF_W-1:0];
  assign dsize       = (block_bytes == '0) ? SIZE_W'(1) : block_bytes;
  assign bound       = (slot_count > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS) : slot_count;
  assign cfg_ready   = 1'b1;

  always_comb begin
    if (free_list_len == '0) begin
      len_sat = COUNT_W'(1);
    end else if (free_list_len > COUNT_W'(MAX_SLOTS)) begin
      len_sat = COUNT_W'(MAX_SLOTS);
    end else begin
      len_sat = free_list_len;
    end
  end

  always_comb begin
    state_next        = state;
    res_load          = 1'b0;
    res_status_next   = ST_OK;
    res_idx_next      = '0;
    res_off_next      = '0;
    pop               = 1'b0;
    push              = 1'b0;
    pool_reset        = 1'b0;
    out_load          = 1'b0;
    arith_req.start   = 1'b0;
    arith_req.op      = OP_DIV;
    arith_req.operand = free_offset[MAG_W-1:0];
    ring_req.clear    = 1'b0;
    ring_req.rd_en    = 1'b0;
    ring_req.rd_addr  = rd_ptr;
    ring_req.wr_en    = 1'b0;
    ring_req.wr_addr  = wr_ptr;
    ring_req.wr_data  = arith_rsp.result[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_ALLOC: begin
              if (free_count == '0) begin
                res_load        = 1'b1;
                res_status_next = ST_NO_MEMORY;
                state_next      = S_DONE;
              end else begin
                ring_req.rd_en = 1'b1;
                state_next     = S_ALLOC_RD;
              end
            end
            MODE_FREE: begin
              if (free_offset[BOFF_W-1]) begin
                res_load        = 1'b1;
                res_status_next = ST_INVALID_POINTER;
                state_next      = S_DONE;
              end else begin
                arith_req.start = 1'b1;
                state_next      = S_DIV;
              end
            end
            MODE_RESET: begin
              pool_reset     = 1'b1;
              ring_req.clear = 1'b1;
              res_load       = 1'b1;
              state_next     = S_DONE;
            end
            default: begin
              res_load   = 1'b1;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        pop               = 1'b1;
        arith_req.start   = 1'b1;
        arith_req.op      = OP_MUL;
        arith_req.operand = MAG_W'(ring_data);
        state_next        = S_MUL;
      end
      S_MUL: begin
        // The ring keeps its read data until the next read, so the index is still there.
        if (arith_rsp.done) begin
          res_load     = 1'b1;
          res_idx_next = ring_data;
          res_off_next = arith_rsp.result[AOFF_W-1:0];
          state_next   = S_DONE;
        end
      end
      S_DIV: begin
        if (arith_rsp.done) begin
          res_load   = 1'b1;
          state_next = S_DONE;
          if (!arith_rsp.rem_zero || (arith_rsp.result >= MAG_W'(bound))) begin
            res_status_next = ST_INVALID_POINTER;
          end else if (free_count >= ring_len) begin
            res_status_next = ST_FREE_LIST_FULL;
          end else begin
            push           = 1'b1;
            ring_req.wr_en = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= COUNT_W'(MAX_SLOTS);
      block_bytes   <= SIZE_W'(1);
      free_list_len <= COUNT_W'(MAX_SLOTS);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_SLOT_COUNT:    slot_count    <= cfg_data[COUNT_W-1:0];
        REG_DATUM_SIZE:    block_bytes   <= cfg_data;
        REG_FREE_LIST_LEN: free_list_len <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      free_count <= COUNT_W'(MAX_SLOTS);
      ring_len   <= COUNT_W'(MAX_SLOTS);
    end else if (pool_reset) begin
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      free_count <= len_sat;
      ring_len   <= len_sat;
    end else if (pop) begin
      rd_ptr     <= advance(rd_ptr, ring_len);
      free_count <= free_count - 1'b1;
    end else if (push) begin
      wr_ptr     <= advance(wr_ptr, ring_len);
      free_count <= free_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status <= res_status_next;
      res_idx    <= res_idx_next;
      res_off    <= res_off_next;
    end
    if (out_load) begin
      out_status <= res_status;
      out_idx    <= res_idx;
      out_off    <= res_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {4'b0, out_off, out_idx};

  fbpa_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .req   (arith_req),
    .dsize (dsize),
    .rsp   (arith_rsp)
  );

  fbpa_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .req     (ring_req),
    .rd_data (ring_data)
  );

endmodule

`default_nettype wire

>>> src/fbpa_arith.sv
// Shared add/subtract unit run as a restoring divider or a shift-add multiplier.
`default_nettype none

module fbpa_arith
  import fbpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire arith_req_t        req,
  input  wire logic [SIZE_W-1:0] dsize,
  output arith_rsp_t             rsp
);

  logic              busy;
  logic              done;
  arith_op_t         op;
  logic [STEP_W-1:0] cnt;
  logic [MAG_W-1:0]  src;
  logic [MAG_W-1:0]  acc;
  logic [REM_W-1:0]  rem;

  logic [REM_W:0]    rem_sh;
  logic [SUM_W-1:0]  opa;
  logic [SUM_W-1:0]  opb;
  logic [SUM_W-1:0]  sum;
  logic              sub;

  // The single adder: subtracts the block size for division steps and adds
  // it (or zero) for multiplication steps.
  always_comb begin
    rem_sh = {rem, src[MAG_W-1]};
    if (op == OP_DIV) begin
      sub = 1'b1;
      opa = SUM_W'(rem_sh);
      opb = SUM_W'(dsize);
    end else begin
      sub = 1'b0;
      opa = {acc, 1'b0};
      opb = src[MAG_W-1] ? SUM_W'(dsize) : '0;
    end
    sum = sub ? (opa - opb) : (opa + opb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == OP_DIV) ? STEP_W'(DIV_STEPS - 1) : STEP_W'(MUL_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      acc <= '0;
      rem <= '0;
      if (req.op == OP_DIV) begin
        src <= req.operand;
      end else begin
        src <= {req.operand[IDX_W-1:0], (MAG_W - IDX_W)'(0)};
      end
    end else if (busy) begin
      src <= {src[MAG_W-2:0], 1'b0};
      if (op == OP_DIV) begin
        // A set sign bit means the trial subtraction went below zero.
        if (!sum[SUM_W-1]) begin
          rem <= sum[REM_W-1:0];
          acc <= {acc[MAG_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[REM_W-1:0];
          acc <= {acc[MAG_W-2:0], 1'b0};
        end
      end else begin
        acc <= sum[MAG_W-1:0];
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.result   = acc;
  assign rsp.rem_zero = (rem == '0);

endmodule

`default_nettype wire

>>> src/fbpa_ring.sv
// Free index ring memory with a fill mark that stands in for the identity refill.
`default_nettype none

module fbpa_ring
  import fbpa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ring_req_t        req,
  output logic [IDX_W-1:0]      rd_data
);

  logic [IDX_W-1:0]   mem [MAX_SLOTS];
  logic [IDX_W-1:0]   rd_q;
  logic [IDX_W-1:0]   rd_addr_q;
  logic [COUNT_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q      <= mem[req.rd_addr];
      rd_addr_q <= req.rd_addr;
    end
  end

  // Pushes after a refill land at positions 0, 1, 2, ... so every position
  // below the fill mark has been written and every one at or above it still
  // reads as its own index.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      fill <= '0;
    end else if (req.wr_en && ({1'b0, req.wr_addr} >= fill)) begin
      fill <= COUNT_W'(req.wr_addr) + 1'b1;
    end
  end

  assign rd_data = ({1'b0, rd_addr_q} >= fill) ? rd_addr_q : rd_q;

endmodule

`default_nettype wire

>>> src/fbpa_checker.sv
// Port-level assertions for the allocator top level, attached by bind.
`default_nettype none

module fbpa_checker
  import fbpa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // Only a successful allocate carries an index and an offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
    else $error("non-ok result carries a nonzero index or offset");

  // The padding bits above the offset stay clear.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[39:36] == 4'b0))
    else $error("padding bits of the result are set");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again right after an item was accepted");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed or dropped");

  // Nothing is presented right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);

`default_nettype wire
